// ----- design/pte_pkg.sv -----
// Shared types and constants for the polynomial table engine.
// Used by the core and by its port checker; depends on nothing else.
`default_nettype none

package pte_pkg;

   // Default table shape
   localparam int NUM_POLYS_DEF     = 8;
   localparam int NUM_EXPONENTS_DEF = 64;

   // Channel widths
   localparam int REQ_TDATA_W = 112;
   localparam int REQ_TUSER_W = 3;
   localparam int RSP_TDATA_W = 32;
   localparam int RSP_TUSER_W = 2;

   typedef enum logic [2:0] {
      FN_CREATE = 3'd0,
      FN_ADD    = 3'd1,
      FN_SCALE  = 3'd2,
      FN_EVAL   = 3'd3,
      FN_DERIVE = 3'd4
   } func_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_EXISTS  = 2'd1,
      ST_MISSING = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_WALK,
      S_DRAIN,
      S_FINISH
   } state_type;

endpackage

`default_nettype wire

// ----- design/polynomial_table_engine_core.sv -----
// Polynomial table engine: coefficient memory walked by a read-modify-write sequencer.
// Depends on pte_pkg. Create, scale, evaluate and derive walk all NUM_EXPONENTS slots, one per
// cycle; add term reads and rewrites one slot; errors and unused codes skip the walk. The next
// request beat is taken once the response beat of the last one is registered.
// A stalled response beat holds the next result and the input.
// Reset clears the valid marks and control state; create or derive writes every slot before a read.
`default_nettype none

module polynomial_table_engine_core #(
   parameter int NUM_POLYS     = pte_pkg::NUM_POLYS_DEF,
   parameter int NUM_EXPONENTS = pte_pkg::NUM_EXPONENTS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output      logic                             req_tready,
   // poly_sel[2:0], dest_sel[5:3], term_coef[37:6], term_expo[43:38],
   // factor[75:44], eval_point[107:76], zero fill[111:108]
   input  wire logic [pte_pkg::REQ_TDATA_W-1:0] req_tdata,
   // func[2:0]
   input  wire logic [pte_pkg::REQ_TUSER_W-1:0] req_tuser,
   output      logic                             rsp_tvalid,
   input  wire logic                             rsp_tready,
   // value[31:0]
   output      logic [pte_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // status[1:0]
   output      logic [pte_pkg::RSP_TUSER_W-1:0] rsp_tuser
);
   import pte_pkg::*;

   localparam int PW    = $clog2(NUM_POLYS);
   localparam int EW    = $clog2(NUM_EXPONENTS);
   localparam int DEPTH = NUM_POLYS * NUM_EXPONENTS;
   localparam int AW    = $clog2(DEPTH);
   localparam logic [EW-1:0] LAST_SLOT = EW'(NUM_EXPONENTS - 1);

   // Request fields
   func_type    in_func;
   logic [2:0]  in_sel;
   logic [2:0]  in_dst;
   logic [31:0] in_coef;
   logic [5:0]  in_expo;
   logic [31:0] in_fac;
   logic [31:0] in_x;

   assign in_func = func_type'(req_tuser);
   assign in_sel  = req_tdata[2:0];
   assign in_dst  = req_tdata[5:3];
   assign in_coef = req_tdata[37:6];
   assign in_expo = req_tdata[43:38];
   assign in_fac  = req_tdata[75:44];
   assign in_x    = req_tdata[107:76];

   // Control state
   state_type            state_ff, state_in;
   func_type             op_ff;
   logic [NUM_POLYS-1:0] valid_ff, valid_in;
   logic [EW-1:0]        idx_ff, idx_in;
   logic [EW-1:0]        last_ff;
   logic [AW-1:0]        rd_base_ff;
   logic [AW-1:0]        wr_base_ff;
   logic [31:0]          coef_ff;
   logic [31:0]          fac_ff;
   logic [31:0]          x_ff;

   // Walk pipeline
   logic                 s1_vld_ff;
   logic [EW-1:0]        s1_idx_ff;
   logic                 s1_last_ff;
   logic [31:0]          q_ff;
   logic [31:0]          pow_ff;
   logic                 s2_vld_ff;
   logic [EW-1:0]        s2_idx_ff;
   logic                 s2_last_ff;
   logic [31:0]          res_ff, res_in;
   logic [31:0]          acc_ff;

   // Pending and output result
   logic [31:0]          val_ff;
   status_type           stat_ff;
   logic                 out_vld_ff, out_vld_in;
   logic [31:0]          out_val_ff;
   status_type           out_stat_ff;

   logic [31:0]          mem [DEPTH];

   // Accept decode
   logic          req_fire;
   logic          sel_ok, dst_ok, sel_live, expo_ok;
   logic [PW-1:0] sel_i, dst_i;
   logic          go_walk, set_valid;
   logic [PW-1:0] set_idx;
   status_type    acc_stat;
   logic [EW-1:0] start_idx, last_idx;
   logic [AW-1:0] sel_base, dst_base, wr_base_sel;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   assign sel_ok   = 32'(in_sel) < 32'(NUM_POLYS);
   assign dst_ok   = 32'(in_dst) < 32'(NUM_POLYS);
   assign sel_i    = PW'(in_sel);
   assign dst_i    = PW'(in_dst);
   assign sel_live = sel_ok && valid_ff[sel_i];
   assign expo_ok  = 32'(in_expo) < 32'(NUM_EXPONENTS);
   assign sel_base = AW'(32'(in_sel) * 32'(NUM_EXPONENTS));
   assign dst_base = AW'(32'(in_dst) * 32'(NUM_EXPONENTS));

   always_comb begin
      go_walk     = 1'b0;
      set_valid   = 1'b0;
      set_idx     = sel_i;
      acc_stat    = ST_OK;
      start_idx   = '0;
      last_idx    = LAST_SLOT;
      wr_base_sel = sel_base;
      unique case (in_func)
         FN_CREATE: begin
            if (!sel_ok) begin
               acc_stat = ST_MISSING;
            end else if (valid_ff[sel_i]) begin
               acc_stat = ST_EXISTS;
            end else begin
               go_walk   = 1'b1;
               set_valid = 1'b1;
            end
         end
         FN_ADD: begin
            if (!sel_live) begin
               acc_stat = ST_MISSING;
            end else if (expo_ok) begin
               go_walk   = 1'b1;
               start_idx = EW'(in_expo);
               last_idx  = EW'(in_expo);
            end
         end
         FN_SCALE, FN_EVAL: begin
            if (!sel_live) begin
               acc_stat = ST_MISSING;
            end else begin
               go_walk = 1'b1;
            end
         end
         FN_DERIVE: begin
            set_idx     = dst_i;
            wr_base_sel = dst_base;
            if (!dst_ok) begin
               acc_stat = ST_MISSING;
            end else if (valid_ff[dst_i]) begin
               acc_stat = ST_EXISTS;
            end else if (!sel_live) begin
               acc_stat = ST_MISSING;
            end else begin
               go_walk   = 1'b1;
               set_valid = 1'b1;
            end
         end
         default: begin
            acc_stat = ST_OK;
         end
      endcase
   end

   // Sequencer
   logic out_free;
   logic walk_end;

   assign out_free = !out_vld_ff || rsp_tready;
   assign walk_end = s2_vld_ff && s2_last_ff;

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      valid_in   = valid_ff;
      out_vld_in = out_vld_ff;
      if (rsp_tready) begin
         out_vld_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               idx_in   = start_idx;
               state_in = go_walk ? S_WALK : S_FINISH;
               if (set_valid) begin
                  valid_in[set_idx] = 1'b1;
               end
            end
         end
         S_WALK: begin
            idx_in = idx_ff + 1'b1;
            if (idx_ff == last_ff) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (walk_end) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               out_vld_in = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         valid_ff   <= '0;
         out_vld_ff <= 1'b0;
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         valid_ff   <= valid_in;
         out_vld_ff <= out_vld_in;
         s1_vld_ff  <= (state_ff == S_WALK);
         s2_vld_ff  <= s1_vld_ff;
      end
   end

   // Operation context, captured with the request beat
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (req_fire) begin
         op_ff      <= in_func;
         last_ff    <= last_idx;
         rd_base_ff <= sel_base;
         wr_base_ff <= wr_base_sel;
         coef_ff    <= in_coef;
         fac_ff     <= in_fac;
         x_ff       <= in_x;
      end
   end

   // Memory port: read issued from the walk, write retired from stage two
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [EW-1:0] wr_off;
   logic [AW-1:0] wr_addr;

   assign rd_en   = (state_ff == S_WALK);
   assign rd_addr = rd_base_ff + AW'(idx_ff);
   assign wr_en   = s2_vld_ff && (op_ff != FN_EVAL);

   // Derive shifts down one slot; slot zero's product (always zero) lands in the top slot
   always_comb begin
      wr_off = s2_idx_ff;
      if (op_ff == FN_DERIVE) begin
         wr_off = (s2_idx_ff == '0) ? LAST_SLOT : s2_idx_ff - 1'b1;
      end
   end

   assign wr_addr = wr_base_ff + AW'(wr_off);

   always_ff @(posedge clock) begin
      if (rd_en) begin
         q_ff <= mem[rd_addr];
      end
      if (wr_en) begin
         mem[wr_addr] <= res_ff;
      end
   end

   // Stage one: per slot, a product (evaluate also steps the power of x), a sum for add term, or zero for create
   logic [31:0] opnd;
   logic [31:0] prod;
   logic [31:0] pow_next;

   always_comb begin
      opnd = fac_ff;
      unique case (op_ff)
         FN_EVAL:   opnd = pow_ff;
         FN_DERIVE: opnd = 32'(s1_idx_ff);
         default:   opnd = fac_ff;
      endcase
   end

   assign prod     = q_ff * opnd;
   assign pow_next = pow_ff * x_ff;

   always_comb begin
      unique case (op_ff)
         FN_CREATE: res_in = '0;
         FN_ADD:    res_in = q_ff + coef_ff;
         default:   res_in = prod;
      endcase
   end

   always_ff @(posedge clock) begin
      s1_idx_ff  <= idx_ff;
      s1_last_ff <= (idx_ff == last_ff);
      s2_idx_ff  <= s1_idx_ff;
      s2_last_ff <= s1_last_ff;
      res_ff     <= res_in;
      if (req_fire) begin
         pow_ff <= 32'd1;
         acc_ff <= '0;
      end else begin
         if (s1_vld_ff) begin
            pow_ff <= pow_next;
         end
         if (s2_vld_ff) begin
            acc_ff <= acc_ff + res_ff;
         end
      end
   end

   // Pending result and output register
   always_ff @(posedge clock) begin
      if (req_fire) begin
         val_ff  <= '0;
         stat_ff <= acc_stat;
      end else if (walk_end && (op_ff == FN_EVAL)) begin
         val_ff <= acc_ff + res_ff;
      end
      if ((state_ff == S_FINISH) && out_free) begin
         out_val_ff  <= val_ff;
         out_stat_ff <= stat_ff;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_val_ff;
   assign rsp_tuser  = out_stat_ff;

endmodule

`default_nettype wire

// ----- design/pte_checker.sv -----
// Port-level checker for the polynomial table engine, bound to the core.
// Depends on pte_pkg and polynomial_table_engine_core.
`default_nettype none

module pte_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_tvalid,
   input wire logic                             req_tready,
   // poly_sel, dest_sel, term_coef, term_expo, factor, eval_point from bit 0 up
   input wire logic [pte_pkg::REQ_TDATA_W-1:0] req_tdata,
   // func
   input wire logic [pte_pkg::REQ_TUSER_W-1:0] req_tuser,
   input wire logic                             rsp_tvalid,
   input wire logic                             rsp_tready,
   // value
   input wire logic [pte_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // status
   input wire logic [pte_pkg::RSP_TUSER_W-1:0] rsp_tuser
);
   import pte_pkg::*;

   logic       req_fire, rsp_fire;
   logic [1:0] pend_ff, pend_in;

   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;

   // Requests accepted whose response beat has not gone out yet
   always_comb begin
      pend_in = pend_ff;
      if (req_fire && !rsp_fire) begin
         pend_in = pend_ff + 1'b1;
      end else if (!req_fire && rsp_fire) begin
         pend_in = pend_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response beat changed while stalled");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> pend_ff != 2'd0)
      else $error("response beat without a pending request");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      pend_ff != 2'd3)
      else $error("more than two requests in flight");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != RSP_TUSER_W'(ST_OK) |-> rsp_tdata == '0)
      else $error("nonzero value with error status");

   logic unused_in;
   assign unused_in = ^{req_tdata, req_tuser};

endmodule

bind polynomial_table_engine_core pte_checker u_pte_checker (.*);

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for polynomial_table_engine_core: a scoreboard class keeps its
// own polynomial table and predicts every response beat; plain tasks drive the request stream.
// Depends on pte_pkg and polynomial_table_engine_core.
`timescale 1ns / 1ps

module tb_top;
   import pte_pkg::*;

   localparam int POLYS = NUM_POLYS_DEF;
   localparam int EXPOS = NUM_EXPONENTS_DEF;
   localparam logic [2:0] FN_SPARE_LO  = 3'd5;
   localparam logic [2:0] FN_SPARE_MID = 3'd6;
   localparam logic [2:0] FN_SPARE_HI  = 3'd7;
   localparam int IDLE_PCT = 38;
   localparam int RANDOM_ITEMS = 550;
   localparam int DRAIN_CYCLES = 80;

   typedef struct {
      logic [31:0] value;
      status_type  status;
   } answer_t;

   class poly_scoreboard;
      bit [31:0] coefs[POLYS][EXPOS];
      bit        live[POLYS];
      answer_t   expected[$];
      int        errors;

      function int pending();
         return expected.size();
      endfunction

      function bit is_live(logic [2:0] sel);
         return sel < POLYS && live[sel];
      endfunction

      // Apply one accepted request to the table and queue its answer.
      function void note_request(logic [2:0] fn, logic [2:0] sel, logic [2:0] dst,
                                 logic [31:0] tcoef, logic [5:0] texpo,
                                 logic [31:0] fac, logic [31:0] x);
         answer_t   ans;
         bit [31:0] src[EXPOS];
         ans.value  = '0;
         ans.status = ST_OK;
         case (fn)
            FN_CREATE: begin
               if (sel >= POLYS) ans.status = ST_MISSING;
               else if (live[sel]) ans.status = ST_EXISTS;
               else begin
                  for (int e = 0; e < EXPOS; e++) coefs[sel][e] = '0;
                  live[sel] = 1'b1;
               end
            end
            FN_ADD: begin
               if (!is_live(sel)) ans.status = ST_MISSING;
               else if (texpo < EXPOS) coefs[sel][texpo] = coefs[sel][texpo] + tcoef;
            end
            FN_SCALE: begin
               if (!is_live(sel)) ans.status = ST_MISSING;
               else for (int e = 0; e < EXPOS; e++) coefs[sel][e] = coefs[sel][e] * fac;
            end
            FN_EVAL: begin
               if (!is_live(sel)) ans.status = ST_MISSING;
               else for (int e = EXPOS - 1; e >= 0; e--)
                  ans.value = ans.value * x + coefs[sel][e];
            end
            FN_DERIVE: begin
               if (dst >= POLYS) ans.status = ST_MISSING;
               else if (live[dst]) ans.status = ST_EXISTS;
               else if (!is_live(sel)) ans.status = ST_MISSING;
               else begin
                  src = coefs[sel];
                  for (int e = 0; e < EXPOS; e++) coefs[dst][e] = '0;
                  live[dst] = 1'b1;
                  for (int e = 1; e < EXPOS; e++)
                     coefs[dst][e-1] = 32'(e) * src[e];
               end
            end
            default: ;
         endcase
         expected.push_back(ans);
      endfunction

      function void check_response(logic [31:0] value, logic [1:0] status);
         answer_t ans;
         if (expected.size() == 0) begin
            $error("response beat with nothing expected: value %0h status %0d",
                   value, status);
            errors++;
            return;
         end
         ans = expected.pop_front();
         if (value !== ans.value) begin
            $error("value mismatch: expected %0h, actual %0h", ans.value, value);
            errors++;
         end
         if (status !== ans.status) begin
            $error("status mismatch: expected %0d, actual %0d", ans.status, status);
            errors++;
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [REQ_TUSER_W-1:0] req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;

   poly_scoreboard board = new();
   bit             calm = 1'b0;

   polynomial_table_engine_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Present one request beat, idling at random first unless calm, and hold it until taken.
   task automatic send_request(input logic [2:0] fn, input logic [2:0] sel,
                               input logic [2:0] dst, input logic [31:0] tcoef,
                               input logic [5:0] texpo, input logic [31:0] fac,
                               input logic [31:0] x);
      while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, x, fac, texpo, tcoef, dst, sel};
      req_tuser  <= fn;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request(fn, sel, dst, tcoef, texpo, fac, x);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_word();
      // half full-range, half near zero so sums and products stay readable
      if ($urandom_range(0, 1)) return $urandom;
      return 32'($urandom_range(0, 20)) - 32'd10;
   endfunction

   task automatic send_random();
      logic [2:0] fn;
      int         r;
      r = $urandom_range(0, 99);
      if (r < 8) fn = FN_CREATE;
      else if (r < 40) fn = FN_ADD;
      else if (r < 52) fn = FN_SCALE;
      else if (r < 82) fn = FN_EVAL;
      else if (r < 94) fn = FN_DERIVE;
      else fn = 3'($urandom_range(FN_SPARE_LO, FN_SPARE_HI));
      send_request(fn, 3'($urandom), 3'($urandom), pick_word(), 6'($urandom),
                   ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 6)) - 32'd3,
                   pick_word());
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready)
         board.check_response(rsp_tdata, rsp_tuser);
      rsp_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // everything missing before any create
      send_request(FN_EVAL,   3'd0, 3'd0, '0, '0, '0, 32'd1);
      send_request(FN_ADD,    3'd0, 3'd0, 32'd5, 6'd1, '0, '0);
      send_request(FN_SCALE,  3'd0, 3'd0, '0, '0, 32'd2, '0);
      send_request(FN_DERIVE, 3'd2, 3'd3, '0, '0, '0, '0);
      send_request(FN_CREATE, 3'd0, 3'd0, '0, '0, '0, '0);
      send_request(FN_CREATE, 3'd0, 3'd0, '0, '0, '0, '0);
      send_request(FN_ADD,    3'd0, 3'd7, 32'h7fff_ffff, 6'd63, '0, '0);
      send_request(FN_ADD,    3'd0, 3'd0, 32'h8000_0000, 6'd0, '0, '0);
      send_request(FN_ADD,    3'd0, 3'd0, 32'hffff_ffff, 6'd1, '0, '0);
      send_request(FN_EVAL,   3'd0, 3'd0, '0, '0, '0, 32'h7fff_ffff);
      send_request(FN_EVAL,   3'd0, 3'd0, '0, '0, '0, 32'h8000_0000);
      send_request(FN_EVAL,   3'd0, 3'd0, '0, '0, '0, 32'd0);
      send_request(FN_EVAL,   3'd0, 3'd0, '0, '0, '0, 32'hffff_ffff);
      send_request(FN_DERIVE, 3'd0, 3'd1, '0, '0, '0, '0);
      send_request(FN_DERIVE, 3'd0, 3'd1, '0, '0, '0, '0);
      send_request(FN_EVAL,   3'd1, 3'd0, '0, '0, '0, 32'd3);
      send_request(FN_SCALE,  3'd0, 3'd0, '0, '0, 32'h8000_0000, '0);
      send_request(FN_SCALE,  3'd1, 3'd0, '0, '0, 32'hffff_ffff, '0);
      send_request(FN_EVAL,   3'd1, 3'd0, '0, '0, '0, 32'd2);
      send_request(FN_SPARE_LO, 3'd7, 3'd7, '1, '1, '1, '1);
      send_request(FN_SPARE_MID, 3'd0, 3'd0, '0, '0, '0, '0);
      send_request(FN_SPARE_HI, 3'd1, 3'd2, '0, '0, '0, '0);
      send_request(FN_CREATE, 3'd7, 3'd0, '0, '0, '0, '0);
      send_request(FN_ADD,    3'd7, 3'd0, 32'd9, 6'd32, '0, '0);
      send_request(FN_EVAL,   3'd7, 3'd0, '0, '0, '0, 32'd1);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         // a stretch with no idling on either side
         calm = (i >= 220 && i < 320);
         if (i == 270) drain_results();
         send_random();
      end
      calm = 1'b0;
      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0)
         $display("polynomial_table_engine_core test passed");
      else
         $display("polynomial_table_engine_core test failed");
      $finish;
   end

   initial begin
      #4_000_000;
      $display("polynomial_table_engine_core test failed");
      $finish;
   end

endmodule
